// File: design/fwoi_pkg.sv
// ----------------------------------------------------------------------------
// fwoi_pkg: shared types and constants for the ordered-insert queue
// Request/response structs, operation and status codes, cell control.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fwoi_pkg;

   localparam int DEPTH       = 16;
   localparam int VALUE_WIDTH = 32;
   localparam int CNT_W       = $clog2(DEPTH + 1);

   typedef enum logic [1:0] {
      OP_APPEND  = 2'd0,
      OP_ORDERED = 2'd1,
      OP_PEEK    = 2'd2,
      OP_DEQUEUE = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      logic [1:0]         operation;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] head_value;
      logic [1:0]         status;
      logic [4:0]         occupancy;
   } rsp_type;

   typedef logic [VALUE_WIDTH-1:0] entry_type;

   // broadcast to every cell in the chain
   typedef struct packed {
      logic      insert_en;
      logic      ordered;
      logic      dequeue_en;
      entry_type value;
   } cell_ctrl_type;

endpackage

// File: design/fwoi_cell.sv
// ----------------------------------------------------------------------------
// fwoi_cell: one queue slot
// Holds one entry, takes the insert value or a neighbor's entry on a shift.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fwoi_cell
   import fwoi_pkg::*;
(
   input  logic          clock,
   input  cell_ctrl_type ctrl,
   input  logic          occupied,   // slot holds a live entry
   input  logic          tail,       // first free slot
   input  logic          hit_in,     // insert point lies to the left
   input  entry_type     left_data,
   input  entry_type     right_data,
   output logic          hit_out,
   output entry_type     data
);

   entry_type data_ff;
   entry_type data_in;
   logic      mark;
   logic      not_less;

   assign not_less = !($signed(data_ff) < $signed(ctrl.value));
   assign mark     = tail | (ctrl.ordered & occupied & not_less);
   assign hit_out  = hit_in | mark;
   assign data     = data_ff;

   always_comb begin
      data_in = data_ff;
      if (ctrl.insert_en) begin
         if (hit_in) begin
            data_in = left_data;
         end else if (mark) begin
            data_in = ctrl.value;
         end
      end else if (ctrl.dequeue_en) begin
         data_in = right_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule

// File: design/fifo_with_ordered_insert.sv
// ----------------------------------------------------------------------------
// fifo_with_ordered_insert: bounded queue with tail append and ordered insert
// A response is registered, valid in the cycle after its request is taken.
// Throughput: one request per cycle unless a response is held; every slot
// compares to the value in parallel; the insert point ripples along the chain.
// Reset: synchronous, clears the count and the response valid; entry data
// is not reset and is only read below the count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fifo_with_ordered_insert
   import fwoi_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   // entry count, 0..DEPTH
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   // response register
   logic    rsp_valid_ff;
   logic    rsp_valid_in;
   rsp_type rsp_data_ff;
   rsp_type rsp_data_in;

   logic          accept;
   logic          is_insert;
   logic          is_read;
   logic          full;
   logic          empty;
   cell_ctrl_type ctrl;

   // chain wiring
   entry_type       cell_data [DEPTH];
   logic [DEPTH:0]  hit;

   // A new request goes in whenever the response slot is free or draining.
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign full  = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);

   always_comb begin
      is_insert = (req_data.operation == OP_APPEND) || (req_data.operation == OP_ORDERED);
      is_read   = !is_insert;

      ctrl.insert_en  = accept & is_insert & ~full;
      ctrl.ordered    = (req_data.operation == OP_ORDERED);
      ctrl.dequeue_en = accept & (req_data.operation == OP_DEQUEUE) & ~empty;
      ctrl.value      = VALUE_WIDTH'(req_data.value);

      count_in = count_ff;
      if (ctrl.insert_en) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ctrl.dequeue_en) begin
         count_in = count_ff - CNT_W'(1);
      end

      // response built from the pre-update head and post-update count
      rsp_data_in            = rsp_data_ff;
      rsp_valid_in           = rsp_valid_ff & rsp_stall;
      if (accept) begin
         rsp_valid_in          = 1'b1;
         rsp_data_in.head_value = '0;
         rsp_data_in.status     = ST_OK;
         rsp_data_in.occupancy  = 5'(count_in);
         if (is_insert && full) begin
            rsp_data_in.status = ST_FULL;
         end else if (is_read && empty) begin
            rsp_data_in.status = ST_EMPTY;
         end else if (is_read) begin
            rsp_data_in.head_value = 32'(signed'(cell_data[0]));
         end
      end
   end

   // Cell chain: slot 0 is the head. The insert point ripples rightward via
   // hit; slots past it take the left neighbor, a dequeue pulls from the right.
   assign hit[0] = 1'b0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      entry_type left_d;
      entry_type right_d;

      if (i == 0) begin : g_first
         assign left_d = ctrl.value;
      end else begin : g_mid
         assign left_d = cell_data[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_d = cell_data[i];
      end else begin : g_body
         assign right_d = cell_data[i+1];
      end

      fwoi_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .occupied   (CNT_W'(i) < count_ff),
         .tail       (CNT_W'(i) == count_ff),
         .hit_in     (hit[i]),
         .left_data  (left_d),
         .right_data (right_d),
         .hit_out    (hit[i+1]),
         .data       (cell_data[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

endmodule
